>>> rtl/bnr_pkg.sv
// Shared types and constants for the Benes network router.
// Used by bnr_ctrl, bnr_dp and benes_network_router_unit; no dependencies.
package bnr_pkg;

	localparam int MAX_SIZE   = 256;
	localparam int IDX_W      = 8;
	localparam int WORD_BITS  = 64;
	localparam int STAGES_MAX = 8;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_PERM   = 2'd1;
	localparam logic [1:0] ST_TOO_MANY   = 2'd2;
	localparam logic [1:0] ST_ROUTE_FAIL = 2'd3;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_INIT_RD,
		CMD_INIT_WR,
		CMD_STAGE,
		CMD_SCAN_NEXT,
		CMD_WALK_START,
		CMD_MARK,
		CMD_SS_RD,
		CMD_SS_W1,
		CMD_SS_W2,
		CMD_LK1,
		CMD_LK2,
		CMD_LK3,
		CMD_TS_RD,
		CMD_TS_W1,
		CMD_TS_W2,
		CMD_LK4,
		CMD_LK5,
		CMD_LK6,
		CMD_STAGE_END,
		CMD_CMP_RD,
		CMD_CMP_NEXT,
		CMD_FAIL,
		CMD_OUT_ERR,
		CMD_OUT_LD,
		CMD_OUT_NEXT
	} cmd_t;

	typedef struct packed {
		logic status_nz;
		logic size_one;
		logic init_done;
		logic scan_done;
		logic scan_skip;
		logic steps_over;
		logic vis_i;
		logic sw;
		logic lk3_sw;
		logic last_stage;
		logic left_nz;
		logic cmp_done;
		logic cmp_ne;
		logic out_last;
	} dp_stat_t;

endpackage

>>> rtl/bnr_ctrl.sv
// Sequencer for the Benes network router: load, pad, route, check, emit.
// Depends on bnr_pkg; drives commands into bnr_dp and reads its status.
module bnr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_entry,
	input  logic              out_stall,
	input  bnr_pkg::dp_stat_t stat,
	output bnr_pkg::cmd_t     cmd,
	output logic              in_stall,
	output logic              out_valid
);
	import bnr_pkg::*;

	typedef enum logic [4:0] {
		S_LOAD, S_DECIDE, S_INIT_RD, S_INIT_WR, S_STAGE, S_SCAN, S_WALK,
		S_SS_RD, S_SS_W1, S_SS_W2, S_LK1, S_LK2, S_LK3, S_TS_RD, S_TS_W1,
		S_TS_W2, S_LK4, S_LK5, S_LK6, S_FAIL, S_CMP_RD, S_CMP_EV,
		S_OUT_ERR_LD, S_OUT_LD, S_OUT
	} state_t;

	state_t state_q, state_d;
	logic   in_stall_q, out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd = CMD_LOAD;
					if (last_entry) state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.status_nz || stat.size_one) state_d = S_OUT_ERR_LD;
				else state_d = S_INIT_RD;
			end
			S_INIT_RD: begin
				cmd     = CMD_INIT_RD;
				state_d = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd     = CMD_INIT_WR;
				state_d = stat.init_done ? S_STAGE : S_INIT_RD;
			end
			S_STAGE: begin
				cmd     = CMD_STAGE;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					cmd = CMD_STAGE_END;
					if (!stat.last_stage) state_d = S_STAGE;
					else if (stat.left_nz) state_d = S_FAIL;
					else state_d = S_CMP_RD;
				end else if (stat.scan_skip) begin
					cmd = CMD_SCAN_NEXT;
				end else begin
					cmd     = CMD_WALK_START;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.steps_over) begin
					state_d = S_FAIL;
				end else if (stat.vis_i) begin
					// cycle closed; it must not close on a pending swap
					if (stat.sw) state_d = S_FAIL;
					else begin
						cmd     = CMD_SCAN_NEXT;
						state_d = S_SCAN;
					end
				end else begin
					cmd     = CMD_MARK;
					state_d = stat.sw ? S_SS_RD : S_LK1;
				end
			end
			S_SS_RD: begin cmd = CMD_SS_RD; state_d = S_SS_W1; end
			S_SS_W1: begin cmd = CMD_SS_W1; state_d = S_SS_W2; end
			S_SS_W2: begin cmd = CMD_SS_W2; state_d = S_LK1; end
			S_LK1:   begin cmd = CMD_LK1;   state_d = S_LK2; end
			S_LK2:   begin cmd = CMD_LK2;   state_d = S_LK3; end
			S_LK3: begin
				cmd     = CMD_LK3;
				state_d = stat.lk3_sw ? S_TS_RD : S_LK4;
			end
			S_TS_RD: begin cmd = CMD_TS_RD; state_d = S_TS_W1; end
			S_TS_W1: begin cmd = CMD_TS_W1; state_d = S_TS_W2; end
			S_TS_W2: begin cmd = CMD_TS_W2; state_d = S_LK4; end
			S_LK4:   begin cmd = CMD_LK4;   state_d = S_LK5; end
			S_LK5:   begin cmd = CMD_LK5;   state_d = S_LK6; end
			S_LK6:   begin cmd = CMD_LK6;   state_d = S_WALK; end
			S_FAIL: begin
				cmd     = CMD_FAIL;
				state_d = S_OUT_ERR_LD;
			end
			S_CMP_RD: begin
				cmd     = CMD_CMP_RD;
				state_d = S_CMP_EV;
			end
			S_CMP_EV: begin
				if (stat.cmp_ne) state_d = S_FAIL;
				else if (stat.cmp_done) state_d = S_OUT_LD;
				else begin
					cmd     = CMD_CMP_NEXT;
					state_d = S_CMP_RD;
				end
			end
			S_OUT_ERR_LD: begin
				cmd     = CMD_OUT_ERR;
				state_d = S_OUT;
			end
			S_OUT_LD: begin
				cmd     = CMD_OUT_LD;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					if (stat.out_last) state_d = S_LOAD;
					else begin
						cmd     = CMD_OUT_NEXT;
						state_d = S_OUT_LD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			in_stall_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			in_stall_q  <= (state_d != S_LOAD);
			out_valid_q <= (state_d == S_OUT);
		end
	end

	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

endmodule

>>> rtl/bnr_dp.sv
// Datapath of the Benes network router: order/inverse memories, visited
// bits, mask stores, counters and the result register. Depends on bnr_pkg.
module bnr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bnr_pkg::cmd_t     cmd,
	input  logic [15:0]       entry_value,
	input  logic              last_entry,
	output bnr_pkg::dp_stat_t stat,
	output logic [1:0]        status,
	output logic [3:0]        stage_index,
	output logic [7:0]        stage_delta,
	output logic [1:0]        word_index,
	output logic [63:0]       mask_word,
	output logic [8:0]        perm_size,
	output logic              last_result
);
	import bnr_pkg::*;

	localparam int MASK_W = MAX_SIZE;

	// memories: source/target order and their inverses
	logic [IDX_W-1:0] so_mem[MAX_SIZE];
	logic [IDX_W-1:0] to_mem[MAX_SIZE];
	logic [IDX_W-1:0] si_mem[MAX_SIZE];
	logic [IDX_W-1:0] ti_mem[MAX_SIZE];

	logic             so_we, to_we, si_we, ti_we;
	logic             so_re, to_re, si_re, ti_re;
	logic [IDX_W-1:0] so_wa, to_wa, si_wa, ti_wa;
	logic [IDX_W-1:0] so_wd, to_wd, si_wd, ti_wd;
	logic [IDX_W-1:0] so_ra0, so_ra1, to_ra0, to_ra1, si_ra0, ti_ra0;
	logic [IDX_W-1:0] so_rd0_q, so_rd1_q, to_rd0_q, to_rd1_q, si_rd0_q, ti_rd0_q;

	// load and check state
	logic [8:0]        cnt_q;
	logic              err1_q, err2_q, dup_q;
	logic [IDX_W-1:0]  max_q;
	logic [MAX_SIZE-1:0] vis_q;

	// routing state
	logic [8:0]       size_q, n_q;
	logic [3:0]       stages_q;
	logic [2:0]       stage_q;
	logic [1:0]       status_q;
	logic [1:0]       wlast_q;
	logic [8:0]       j_q, idx_q;
	logic [IDX_W-1:0] i_q, ti_q;
	logic             sw_q;
	logic [9:0]       steps_q;
	logic [3:0]       ok_q;
	logic [1:0]       ow_q;

	logic [MASK_W-1:0] cur_l_q, cur_r_q;
	logic [MASK_W-1:0] lm_q[STAGES_MAX];
	logic [MASK_W-1:0] rm_q[STAGES_MAX];

	logic [1:0]  o_status_q, o_word_q;
	logic [3:0]  o_stage_q;
	logic [7:0]  o_delta_q;
	logic [63:0] o_mask_q;
	logic [8:0]  o_size_q;
	logic        o_last_q;

	logic [IDX_W-1:0] d;
	assign d = 8'd1 << stage_q;

	// load-side combinational terms
	logic             oor, stored, err1_f, err2_f, dup_f;
	logic [IDX_W-1:0] v8, max_f;
	logic [8:0]       cnt_f, cm1;
	logic [3:0]       stg_f;
	logic [1:0]       st_f;

	always_comb begin
		oor    = |entry_value[15:8];
		v8     = oor ? 8'd0 : entry_value[7:0];
		stored = !cnt_q[8];
		cnt_f  = cnt_q + {8'd0, stored};
		err2_f = err2_q | !stored;
		err1_f = err1_q | (stored & oor);
		dup_f  = dup_q | (stored & vis_q[v8]);
		max_f  = (stored && (v8 > max_q)) ? v8 : max_q;
		cm1    = cnt_f - 9'd1;
		stg_f  = 4'd0;
		for (int b = 0; b < IDX_W; b++) begin
			if (cm1[b]) stg_f = 4'(b + 1);
		end
		if (err2_f) st_f = ST_TOO_MANY;
		else if (err1_f || dup_f || ({1'b0, max_f} >= cnt_f)) st_f = ST_BAD_PERM;
		else st_f = ST_OK;
	end

	// walk terms
	logic [IDX_W-1:0] ti_rd, lk3_ti;
	logic             lk3_sw, lk6_sw;
	always_comb begin
		ti_rd  = ti_rd0_q;
		lk3_sw = ((ti_rd & d) != 8'd0) != ((i_q & d) != 8'd0);
		lk3_ti = lk3_sw ? ti_rd : (ti_rd ^ d);
		lk6_sw = ((si_rd0_q & d) != 8'd0) != ((ti_q & d) != 8'd0);
	end

	// output selection
	logic [4:0]        k5, two_s_m2, rsel;
	logic              left_sel;
	logic [2:0]        s_sel;
	logic [MASK_W-1:0] mask_sel;
	always_comb begin
		k5       = {1'b0, ok_q};
		two_s_m2 = {stages_q, 1'b0} - 5'd2;
		rsel     = two_s_m2 - k5;
		left_sel = (k5 + 5'd1) < {1'b0, stages_q};
		s_sel    = left_sel ? ok_q[2:0] : rsel[2:0];
		mask_sel = left_sel ? lm_q[s_sel] : rm_q[s_sel];
	end

	// memory port control
	always_comb begin
		so_we = 1'b0; to_we = 1'b0; si_we = 1'b0; ti_we = 1'b0;
		so_re = 1'b0; to_re = 1'b0; si_re = 1'b0; ti_re = 1'b0;
		so_wa = i_q; so_wd = so_rd1_q;
		to_wa = ti_q; to_wd = to_rd1_q;
		si_wa = so_rd1_q; si_wd = i_q;
		ti_wa = to_rd1_q; ti_wd = ti_q;
		so_ra0 = i_q; so_ra1 = i_q ^ d;
		to_ra0 = ti_q; to_ra1 = ti_q ^ d;
		si_ra0 = to_rd0_q; ti_ra0 = so_rd0_q;
		case (cmd)
			CMD_LOAD: begin
				to_we = stored;
				to_wa = cnt_q[7:0];
				to_wd = v8;
			end
			CMD_INIT_RD: begin
				to_re  = 1'b1;
				to_ra0 = j_q[7:0];
			end
			CMD_INIT_WR: begin
				// positions past the loaded entries are padded with identity
				to_we = 1'b1; to_wa = j_q[7:0];
				to_wd = (j_q >= size_q) ? j_q[7:0] : to_rd0_q;
				so_we = 1'b1; so_wa = j_q[7:0]; so_wd = j_q[7:0];
				si_we = 1'b1; si_wa = j_q[7:0]; si_wd = j_q[7:0];
				ti_we = 1'b1; ti_wa = to_wd;    ti_wd = j_q[7:0];
			end
			CMD_SS_RD: so_re = 1'b1;
			CMD_SS_W1: begin
				so_we = 1'b1; so_wa = i_q; so_wd = so_rd1_q;
				si_we = 1'b1; si_wa = so_rd1_q; si_wd = i_q;
			end
			CMD_SS_W2: begin
				so_we = 1'b1; so_wa = i_q ^ d; so_wd = so_rd0_q;
				si_we = 1'b1; si_wa = so_rd0_q; si_wd = i_q ^ d;
			end
			CMD_LK1: so_re = 1'b1;
			CMD_LK2: ti_re = 1'b1;
			CMD_TS_RD: to_re = 1'b1;
			CMD_TS_W1: begin
				to_we = 1'b1; to_wa = ti_q; to_wd = to_rd1_q;
				ti_we = 1'b1; ti_wa = to_rd1_q; ti_wd = ti_q;
			end
			CMD_TS_W2: begin
				to_we = 1'b1; to_wa = ti_q ^ d; to_wd = to_rd0_q;
				ti_we = 1'b1; ti_wa = to_rd0_q; ti_wd = ti_q ^ d;
			end
			CMD_LK4: to_re = 1'b1;
			CMD_LK5: si_re = 1'b1;
			CMD_CMP_RD: begin
				so_re = 1'b1; so_ra0 = j_q[7:0];
				to_re = 1'b1; to_ra0 = j_q[7:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (so_we) so_mem[so_wa] <= so_wd;
		if (so_re) begin
			so_rd0_q <= so_mem[so_ra0];
			so_rd1_q <= so_mem[so_ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (to_we) to_mem[to_wa] <= to_wd;
		if (to_re) begin
			to_rd0_q <= to_mem[to_ra0];
			to_rd1_q <= to_mem[to_ra1];
		end
	end

	always_ff @(posedge clk) begin
		if (si_we) si_mem[si_wa] <= si_wd;
		if (si_re) si_rd0_q <= si_mem[si_ra0];
	end

	always_ff @(posedge clk) begin
		if (ti_we) ti_mem[ti_wa] <= ti_wd;
		if (ti_re) ti_rd0_q <= ti_mem[ti_ra0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			err1_q   <= 1'b0;
			err2_q   <= 1'b0;
			dup_q    <= 1'b0;
			max_q    <= '0;
			vis_q    <= '0;
			size_q   <= '0;
			n_q      <= '0;
			stages_q <= '0;
			stage_q  <= '0;
			status_q <= ST_OK;
			wlast_q  <= '0;
			j_q      <= '0;
			idx_q    <= '0;
			i_q      <= '0;
			ti_q     <= '0;
			sw_q     <= 1'b0;
			steps_q  <= '0;
			ok_q     <= '0;
			ow_q     <= '0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					if (stored && !last_entry) vis_q[v8] <= 1'b1;
					if (last_entry) begin
						cnt_q    <= '0;
						err1_q   <= 1'b0;
						err2_q   <= 1'b0;
						dup_q    <= 1'b0;
						max_q    <= '0;
						vis_q    <= '0;
						size_q   <= cnt_f;
						status_q <= st_f;
						stages_q <= stg_f;
						n_q      <= 9'd1 << stg_f;
						wlast_q  <= (stg_f == 4'd8) ? 2'd3 : ((stg_f == 4'd7) ? 2'd1 : 2'd0);
						stage_q  <= '0;
						j_q      <= '0;
					end else begin
						cnt_q  <= cnt_f;
						err1_q <= err1_f;
						err2_q <= err2_f;
						dup_q  <= dup_f;
						max_q  <= max_f;
					end
				end
				CMD_INIT_WR: j_q <= j_q + 9'd1;
				CMD_STAGE: begin
					vis_q <= '0;
					idx_q <= '0;
				end
				CMD_SCAN_NEXT: idx_q <= idx_q + 9'd1;
				CMD_WALK_START: begin
					i_q     <= idx_q[7:0] | d;
					sw_q    <= 1'b0;
					steps_q <= '0;
				end
				CMD_MARK: begin
					vis_q <= vis_q | ({{(MAX_SIZE-1){1'b0}}, 1'b1} << i_q)
						| ({{(MAX_SIZE-1){1'b0}}, 1'b1} << (i_q ^ d));
					if (!sw_q) i_q <= i_q ^ d;
				end
				CMD_LK3: begin
					sw_q <= lk3_sw;
					ti_q <= lk3_ti;
				end
				CMD_LK6: begin
					sw_q    <= lk6_sw;
					i_q     <= si_rd0_q;
					steps_q <= steps_q + 10'd1;
				end
				CMD_STAGE_END: begin
					vis_q <= '0;
					if (!stat.last_stage) stage_q <= stage_q + 3'd1;
					j_q  <= '0;
					ok_q <= '0;
					ow_q <= '0;
				end
				CMD_CMP_NEXT: j_q <= j_q + 9'd1;
				CMD_FAIL: begin
					vis_q    <= '0;
					status_q <= ST_ROUTE_FAIL;
				end
				CMD_OUT_NEXT: begin
					if (ow_q == wlast_q) begin
						ow_q <= '0;
						ok_q <= ok_q + 4'd1;
					end else begin
						ow_q <= ow_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// mask and result registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_STAGE: begin
				cur_l_q <= '0;
				cur_r_q <= '0;
			end
			CMD_SS_W1: cur_l_q[i_q & ~d] <= ~cur_l_q[i_q & ~d];
			CMD_TS_W1: cur_r_q[ti_q & ~d] <= ~cur_r_q[ti_q & ~d];
			CMD_STAGE_END: begin
				lm_q[stage_q] <= cur_l_q;
				rm_q[stage_q] <= cur_r_q;
			end
			CMD_OUT_ERR: begin
				o_status_q <= status_q;
				o_stage_q  <= '0;
				o_delta_q  <= '0;
				o_word_q   <= '0;
				o_mask_q   <= '0;
				o_size_q   <= (status_q == ST_TOO_MANY) ? 9'd0 : size_q;
				o_last_q   <= 1'b1;
			end
			CMD_OUT_LD: begin
				o_status_q <= ST_OK;
				o_stage_q  <= ok_q;
				o_delta_q  <= 8'd1 << s_sel;
				o_word_q   <= ow_q;
				o_mask_q   <= mask_sel[{ow_q, 6'd0} +: WORD_BITS];
				o_size_q   <= size_q;
				o_last_q   <= (k5 == two_s_m2) && (ow_q == wlast_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.status_nz  = (status_q != ST_OK);
		stat.size_one   = (size_q == 9'd1);
		stat.init_done  = (j_q == n_q - 9'd1);
		stat.scan_done  = (idx_q == n_q);
		stat.scan_skip  = ((idx_q[7:0] & d) != 8'd0) || vis_q[idx_q[7:0]];
		stat.steps_over = (steps_q > {1'b0, n_q});
		stat.vis_i      = vis_q[i_q];
		stat.sw         = sw_q;
		stat.lk3_sw     = lk3_sw;
		stat.last_stage = ({1'b0, stage_q} == stages_q - 4'd1);
		stat.left_nz    = (cur_l_q != '0);
		stat.cmp_done   = (j_q == n_q - 9'd1);
		stat.cmp_ne     = (so_rd0_q != to_rd0_q);
		stat.out_last   = o_last_q;
	end

	assign status      = o_status_q;
	assign stage_index = o_stage_q;
	assign stage_delta = o_delta_q;
	assign word_index  = o_word_q;
	assign mask_word   = o_mask_q;
	assign perm_size   = o_size_q;
	assign last_result = o_last_q;

endmodule

>>> rtl/benes_network_router_unit.sv
// Top level of the Benes network router: sequencer plus datapath.
// Depends on bnr_pkg, bnr_ctrl and bnr_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_stall  | entry_value, last_entry
//   out     | out_valid / out_stall| status, stage_index, stage_delta, word_index,
//           |                      | mask_word, perm_size, last_result
//
// Non-final entries are taken as they arrive. After the final entry the block
// pads (identity up to a power of two), routes each stage (a scan per index
// plus walk steps, bounded by the single write port per order memory),
// compares the orders index by index, then emits the results one at a time.
// Input is stalled from the final entry until the last result is taken.
// Reset clears all control state; the order memories need no clearing.
module benes_network_router_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] entry_value,
	input  logic        last_entry,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  stage_index,
	output logic [7:0]  stage_delta,
	output logic [1:0]  word_index,
	output logic [63:0] mask_word,
	output logic [8:0]  perm_size,
	output logic        last_result
);
	import bnr_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	bnr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_entry (last_entry),
		.out_stall  (out_stall),
		.stat       (stat),
		.cmd        (cmd),
		.in_stall   (in_stall),
		.out_valid  (out_valid)
	);

	bnr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_value (entry_value),
		.last_entry  (last_entry),
		.stat        (stat),
		.status      (status),
		.stage_index (stage_index),
		.stage_delta (stage_delta),
		.word_index  (word_index),
		.mask_word   (mask_word),
		.perm_size   (perm_size),
		.last_result (last_result)
	);

endmodule
